// File: src/baro_second_order_compensation_macros.svh
// assertion helpers shared by the compensation pipeline
`ifndef BARO_SECOND_ORDER_COMPENSATION_MACROS_SVH
`define BARO_SECOND_ORDER_COMPENSATION_MACROS_SVH

// property checked at every rising clock edge outside reset
`define BSOC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// consequence checked in the cycle after the antecedent
`define BSOC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/bsoc_pkg.sv
package bsoc_pkg;

  // pipeline depth from input acceptance to output register
  localparam int NUM_STAGES = 10;

  // temperature thresholds in hundredths of a degree
  localparam int TEMP_REF  = 2000;
  localparam int TEMP_COLD = -1500;

  // reset values of the plausibility window in pascals
  localparam logic [16:0] FLOOR_RST = 17'd30000;
  localparam logic [16:0] CEIL_RST  = 17'd110000;

  // register map, one 32-bit word each
  typedef enum logic [2:0] {
    REG_C1    = 3'd0,
    REG_C2    = 3'd1,
    REG_C3    = 3'd2,
    REG_C4    = 3'd3,
    REG_C5    = 3'd4,
    REG_C6    = 3'd5,
    REG_FLOOR = 3'd6,
    REG_CEIL  = 3'd7
  } reg_idx_e;

  // one raw sample pair
  typedef struct packed {
    logic [23:0] raw_pressure;
    logic [23:0] raw_temperature;
  } in_req_t;

  // one compensated result
  typedef struct packed {
    logic signed [18:0] temperature_centi;
    logic signed [27:0] pressure_pascal;
    logic               pressure_valid;
  } out_rsp_t;

endpackage

// File: src/baro_second_order_compensation.sv
// Barometer second-order compensation. Each request carries a raw pressure and
// raw temperature reading; the block returns temperature in 0.01 degC, pressure
// in pascals and a flag telling whether the pressure lies in the configured
// window. It is a 10-stage pipeline: one request is taken every clock cycle unless
// the output stalls. When the output register holds a result that is not taken,
// the whole pipeline stalls and input ready drops. The final 24x40-bit pressure
// product is split into two narrower partial products summed in the next stage.
// Calibration words and the window are written over the APB port (word i at byte
// address 4*i); the user must change them only while the pipeline is empty, and
// the block itself does not enforce this.
`include "baro_second_order_compensation_macros.svh"

module baro_second_order_compensation
  import bsoc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // request channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_req_t     in_data_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_rsp_t    out_data_o,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // configuration registers
  logic [15:0] coeff_c1_q, coeff_c2_q, coeff_c3_q, coeff_c4_q, coeff_c5_q, coeff_c6_q;
  logic [16:0] pressure_floor_q, pressure_ceiling_q;
  reg_idx_e    reg_idx;
  logic        cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[4:2]);
  assign cfg_wr  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coeff_c1_q         <= '0;
      coeff_c2_q         <= '0;
      coeff_c3_q         <= '0;
      coeff_c4_q         <= '0;
      coeff_c5_q         <= '0;
      coeff_c6_q         <= '0;
      pressure_floor_q   <= FLOOR_RST;
      pressure_ceiling_q <= CEIL_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_C1:    coeff_c1_q         <= pwdata[15:0];
        REG_C2:    coeff_c2_q         <= pwdata[15:0];
        REG_C3:    coeff_c3_q         <= pwdata[15:0];
        REG_C4:    coeff_c4_q         <= pwdata[15:0];
        REG_C5:    coeff_c5_q         <= pwdata[15:0];
        REG_C6:    coeff_c6_q         <= pwdata[15:0];
        REG_FLOOR: pressure_floor_q   <= pwdata[16:0];
        REG_CEIL:  pressure_ceiling_q <= pwdata[16:0];
        default:   ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (reg_idx)
      REG_C1:    prdata = 32'(coeff_c1_q);
      REG_C2:    prdata = 32'(coeff_c2_q);
      REG_C3:    prdata = 32'(coeff_c3_q);
      REG_C4:    prdata = 32'(coeff_c4_q);
      REG_C5:    prdata = 32'(coeff_c5_q);
      REG_C6:    prdata = 32'(coeff_c6_q);
      REG_FLOOR: prdata = 32'(pressure_floor_q);
      REG_CEIL:  prdata = 32'(pressure_ceiling_q);
      default:   prdata = '0;
    endcase
  end

  // pipeline advance and valid bits
  logic                  advance;
  logic [NUM_STAGES-1:0] vld_q;

  assign advance     = !vld_q[NUM_STAGES-1] || out_ready_i;
  assign in_ready_o  = advance;
  assign out_valid_o = vld_q[NUM_STAGES-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (advance) begin
      vld_q <= {vld_q[NUM_STAGES-2:0], in_valid_i};
    end
  end

  // stage 1: temperature difference
  logic signed [24:0] dt_d, s1_dt_q;
  logic        [23:0] s1_d1_q;

  assign dt_d = $signed({1'b0, in_data_i.raw_temperature}) - $signed({1'b0, coeff_c5_q, 8'h00});

  // stage 2: first-order products
  logic signed [40:0] p6_d, p4_d, p3_d, s2_p6_q, s2_p4_q, s2_p3_q;
  logic signed [49:0] sq_d;
  logic        [16:0] s2_t2_q;
  logic        [23:0] s2_d1_q;

  assign p6_d = 41'(s1_dt_q) * 41'($signed({1'b0, coeff_c6_q}));
  assign p4_d = 41'(s1_dt_q) * 41'($signed({1'b0, coeff_c4_q}));
  assign p3_d = 41'(s1_dt_q) * 41'($signed({1'b0, coeff_c3_q}));
  assign sq_d = 50'(s1_dt_q) * 50'(s1_dt_q);

  // stage 3: first-order temperature, offset, sensitivity
  logic signed [17:0] dev_d, s3_dev_q;
  logic signed [33:0] off_sh;
  logic signed [32:0] sens_sh;
  logic signed [18:0] temp_d, adjb_d, s3_temp_q, s3_adjb_q;
  logic signed [39:0] off_d, sens_d, s3_off_q, s3_sens_q;
  logic               s3_cold_q, s3_vcold_q;
  logic        [16:0] s3_t2_q;
  logic        [23:0] s3_d1_q;

  assign dev_d   = s2_p6_q[40:23];
  assign off_sh  = s2_p4_q[40:7];
  assign sens_sh = s2_p3_q[40:8];
  assign temp_d  = 19'(dev_d) + 19'(TEMP_REF);
  assign adjb_d  = temp_d - 19'(TEMP_COLD);
  assign off_d   = $signed({8'h00, coeff_c2_q, 16'h0000}) + 40'(off_sh);
  assign sens_d  = $signed({9'h000, coeff_c1_q, 15'h0000}) + 40'(sens_sh);

  // stage 4: squared deviations
  logic signed [35:0] dev2_full;
  logic signed [37:0] adj_full;
  logic        [34:0] s4_dev2_q, s4_adj_q;
  logic signed [18:0] s4_temp_q;
  logic signed [39:0] s4_off_q, s4_sens_q;
  logic               s4_cold_q, s4_vcold_q;
  logic        [16:0] s4_t2_q;
  logic        [23:0] s4_d1_q;

  assign dev2_full = 36'(s3_dev_q) * 36'(s3_dev_q);
  assign adj_full  = 38'(s3_adjb_q) * 38'(s3_adjb_q);

  // stage 5: second-order offset and sensitivity corrections
  logic [37:0] f5, a7, off2_d, sens2_d, s5_off2_q, s5_sens2_q;
  logic [38:0] a11;
  logic signed [18:0] s5_temp_q;
  logic signed [39:0] s5_off_q, s5_sens_q;
  logic               s5_cold_q;
  logic        [16:0] s5_t2_q;
  logic        [23:0] s5_d1_q;

  assign f5      = 38'(s4_dev2_q) + 38'({s4_dev2_q, 2'b00});
  assign a7      = 38'({s4_adj_q, 3'b000}) - 38'(s4_adj_q);
  assign a11     = 39'({s4_adj_q, 3'b000}) + 39'({s4_adj_q, 1'b0}) + 39'(s4_adj_q);
  assign off2_d  = (f5 >> 1) + (s4_vcold_q ? a7 : '0);
  assign sens2_d = (f5 >> 2) + (s4_vcold_q ? 38'(a11 >> 1) : '0);

  // stage 6: apply corrections below the reference temperature
  logic signed [18:0] temp6_d, s6_temp_q;
  logic signed [39:0] off6_d, sens6_d, s6_off_q, s6_sens_q;
  logic               s6_cold_q;
  logic        [23:0] s6_d1_q;

  assign temp6_d = s5_cold_q ? s5_temp_q - $signed(19'(s5_t2_q)) : s5_temp_q;
  assign off6_d  = s5_cold_q ? s5_off_q - $signed(40'(s5_off2_q)) : s5_off_q;
  assign sens6_d = s5_cold_q ? s5_sens_q - $signed(40'(s5_sens2_q)) : s5_sens_q;

  // stage 7: raw pressure times sensitivity, two partial products
  logic        [19:0] sens_lo;
  logic signed [19:0] sens_hi;
  logic        [43:0] plo_d, s7_plo_q;
  logic signed [44:0] phi_d, s7_phi_q;
  logic signed [39:0] s7_off_q;
  logic signed [18:0] s7_temp_q;

  assign sens_lo = s6_sens_q[19:0];
  assign sens_hi = s6_sens_q[39:20];
  assign plo_d   = 44'(s6_d1_q) * 44'(sens_lo);
  assign phi_d   = 45'($signed({1'b0, s6_d1_q})) * 45'(sens_hi);

  // stage 8: combine partial products
  logic signed [63:0] prod_d, s8_prod_q;
  logic signed [39:0] s8_off_q;
  logic signed [18:0] s8_temp_q;

  assign prod_d = $signed({s7_phi_q[43:0], 20'h00000}) + $signed({20'h00000, s7_plo_q});

  // stage 9: pressure from scaled product minus offset
  logic signed [42:0] prod_sh;
  logic signed [43:0] x_d;
  logic signed [27:0] s9_p_q;
  logic signed [18:0] s9_temp_q;

  assign prod_sh = s8_prod_q[63:21];
  assign x_d     = 44'(prod_sh) - 44'(s8_off_q);

  // stage 10: window check into output register
  out_rsp_t out_d, out_q;

  always_comb begin
    out_d.temperature_centi = s9_temp_q;
    out_d.pressure_pascal   = s9_p_q;
    out_d.pressure_valid    = !s9_p_q[27]
                              && (s9_p_q[26:0] >= 27'(pressure_floor_q))
                              && (s9_p_q[26:0] <= 27'(pressure_ceiling_q));
  end

  assign out_data_o = out_q;

  // pipeline payload registers
  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_dt_q    <= dt_d;
      s1_d1_q    <= in_data_i.raw_pressure;

      s2_p6_q    <= p6_d;
      s2_p4_q    <= p4_d;
      s2_p3_q    <= p3_d;
      s2_t2_q    <= sq_d[47:31];
      s2_d1_q    <= s1_d1_q;

      s3_dev_q   <= dev_d;
      s3_adjb_q  <= adjb_d;
      s3_temp_q  <= temp_d;
      s3_off_q   <= off_d;
      s3_sens_q  <= sens_d;
      s3_cold_q  <= temp_d < 19'(TEMP_REF);
      s3_vcold_q <= temp_d < 19'(TEMP_COLD);
      s3_t2_q    <= s2_t2_q;
      s3_d1_q    <= s2_d1_q;

      s4_dev2_q  <= dev2_full[34:0];
      s4_adj_q   <= adj_full[34:0];
      s4_temp_q  <= s3_temp_q;
      s4_off_q   <= s3_off_q;
      s4_sens_q  <= s3_sens_q;
      s4_cold_q  <= s3_cold_q;
      s4_vcold_q <= s3_vcold_q;
      s4_t2_q    <= s3_t2_q;
      s4_d1_q    <= s3_d1_q;

      s5_off2_q  <= off2_d;
      s5_sens2_q <= sens2_d;
      s5_temp_q  <= s4_temp_q;
      s5_off_q   <= s4_off_q;
      s5_sens_q  <= s4_sens_q;
      s5_cold_q  <= s4_cold_q;
      s5_t2_q    <= s4_t2_q;
      s5_d1_q    <= s4_d1_q;

      s6_temp_q  <= temp6_d;
      s6_off_q   <= off6_d;
      s6_sens_q  <= sens6_d;
      s6_cold_q  <= s5_cold_q;
      s6_d1_q    <= s5_d1_q;

      s7_plo_q   <= plo_d;
      s7_phi_q   <= phi_d;
      s7_off_q   <= s6_off_q;
      s7_temp_q  <= s6_temp_q;

      s8_prod_q  <= prod_d;
      s8_off_q   <= s7_off_q;
      s8_temp_q  <= s7_temp_q;

      s9_p_q     <= x_d[42:15];
      s9_temp_q  <= s8_temp_q;

      out_q      <= out_d;
    end
  end

  // checks
  `BSOC_ASSERT(a_cold_matches_temp, vld_q[5] |-> (s6_cold_q == (s6_temp_q < 19'(TEMP_REF))), "cold flag disagrees with corrected temperature")
  `BSOC_ASSERT(a_vcold_implies_cold, (vld_q[2] && s3_vcold_q) |-> s3_cold_q, "extra correction without second-order correction")
  `BSOC_ASSERT_NEXT(a_stall_freezes, !in_ready_o, $stable(vld_q) && $stable(out_q), "pipeline moved while stalled")
  `BSOC_ASSERT(a_valid_nonneg, (out_valid_o && out_data_o.pressure_valid) |-> !out_data_o.pressure_pascal[27], "negative pressure flagged plausible")

endmodule
